// ===== rtl/core/mtk_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mtk_pkg
// Shared types, codes and the quarter-wave sine table function of the
// Morse tone keyer.
// ----------------------------------------------------------------------------
package mtk_pkg;

    // sine table geometry: SINE_TABLE_DEPTH = 2**SINE_ADDR_BITS
    localparam int SINE_ADDR_BITS   = 10;
    localparam int SINE_TABLE_DEPTH = 1 << SINE_ADDR_BITS;
    localparam int SINE_IDX_BITS    = SINE_ADDR_BITS + 1;
    localparam int SINE_BITS        = 15;
    localparam int PHASE_BITS       = 32;

    localparam int SPU_BITS    = 16;
    localparam int STEP_BITS   = 31;
    localparam int AMP_BITS    = 15;
    localparam int SAMPLE_BITS = 16;
    localparam int PATTERN_BITS = 4;
    localparam int UNITS_BITS  = 3;

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 31;

    // register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SAMPLES_PER_UNIT = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PHASE_STEP       = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_AMPLITUDE        = 2'd2;

    localparam logic [SPU_BITS-1:0]  SPU_RESET   = 16'd4410;
    localparam logic [STEP_BITS-1:0] STEP_RESET  = 31'd102261126;
    localparam logic [AMP_BITS-1:0]  AMP_RESET   = 15'd32000;

    // command codes
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    localparam logic [1:0] SYM_DOT     = 2'd0;
    localparam logic [1:0] SYM_DASH    = 2'd1;
    localparam logic [1:0] SYM_SPACE   = 2'd2;
    localparam logic [1:0] SYM_INVALID = 2'd3;

    // unit patterns and lengths per symbol
    localparam logic [PATTERN_BITS-1:0] PAT_DOT   = 4'h1;
    localparam logic [PATTERN_BITS-1:0] PAT_DASH  = 4'h7;
    localparam logic [PATTERN_BITS-1:0] PAT_SPACE = 4'h0;
    localparam logic [UNITS_BITS-1:0]   LEN_DOT   = 3'd2;
    localparam logic [UNITS_BITS-1:0]   LEN_DASH  = 3'd4;
    localparam logic [UNITS_BITS-1:0]   LEN_SPACE = 3'd2;

    localparam longint unsigned Q30_HALF_PI = 64'd1686629713;

    // flags travelling with a word from the sequencer to the output stage
    typedef struct packed {
        logic valid;
        logic sample_valid;
        logic accepted;
        logic busy_res;
        logic tone_on;
        logic negative;
    } mtk_stage_t;

    // round(32767 * sin(pi/2 * k / depth)) via a q30 taylor series
    function automatic logic [SINE_BITS-1:0] quarter_entry(input int unsigned k);
        longint unsigned x;
        longint unsigned term;
        longint sum;
        longint unsigned res;
        x    = (Q30_HALF_PI * longint'(k)) / SINE_TABLE_DEPTH;
        term = x;
        sum  = longint'(x);
        term = (term * x) >> 30; term = (term * x) >> 30; term = term / 64'd6;
        sum  = sum - longint'(term);
        term = (term * x) >> 30; term = (term * x) >> 30; term = term / 64'd20;
        sum  = sum + longint'(term);
        term = (term * x) >> 30; term = (term * x) >> 30; term = term / 64'd42;
        sum  = sum - longint'(term);
        term = (term * x) >> 30; term = (term * x) >> 30; term = term / 64'd72;
        sum  = sum + longint'(term);
        term = (term * x) >> 30; term = (term * x) >> 30; term = term / 64'd110;
        sum  = sum - longint'(term);
        term = (term * x) >> 30; term = (term * x) >> 30; term = term / 64'd156;
        sum  = sum + longint'(term);
        term = (term * x) >> 30; term = (term * x) >> 30; term = term / 64'd210;
        sum  = sum - longint'(term);
        if (sum < 0)
        begin
            sum = 0;
        end
        res = ((longint'(sum) * 64'd32767) + (64'd1 << 29)) >> 30;
        return res[SINE_BITS-1:0];
    endfunction

endpackage : mtk_pkg
`default_nettype wire

// ===== rtl/core/mtk_cmd_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mtk_cmd_if
// Command channel: tick or symbol load words.
// ----------------------------------------------------------------------------
interface mtk_cmd_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [1:0] symbol;

    modport source (output valid, output op, output symbol, input ready);
    modport sink   (input valid, input op, input symbol, output ready);
endinterface : mtk_cmd_if
`default_nettype wire

// ===== rtl/core/mtk_res_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mtk_res_if
// Result channel: one word per command word.
// ----------------------------------------------------------------------------
interface mtk_res_if;
    logic                                     valid;
    logic                                     ready;
    logic signed [mtk_pkg::SAMPLE_BITS-1:0]   sample;
    logic                                     sample_valid;
    logic                                     accepted;
    logic                                     busy_res;

    modport source (output valid, output sample, output sample_valid,
                    output accepted, output busy_res, input ready);
    modport sink   (input valid, input sample, input sample_valid,
                    input accepted, input busy_res, output ready);
endinterface : mtk_res_if
`default_nettype wire

// ===== rtl/core/mtk_cfg_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mtk_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface mtk_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [mtk_pkg::CFG_INDEX_BITS-1:0]  index;
    logic [mtk_pkg::CFG_DATA_BITS-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface : mtk_cfg_if
`default_nettype wire

// ===== rtl/core/mtk_sine_rom.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mtk_sine_rom
// Quarter-wave q15 sine table with a registered read port.
// ----------------------------------------------------------------------------
module mtk_sine_rom (
    input  wire logic                               clk,
    input  wire logic                               en,
    input  wire logic [mtk_pkg::SINE_IDX_BITS-1:0]  addr,
    output logic      [mtk_pkg::SINE_BITS-1:0]      data
);

    localparam int Entries = mtk_pkg::SINE_TABLE_DEPTH + 1;

    logic [mtk_pkg::SINE_BITS-1:0] rom [0:Entries-1];
    logic [mtk_pkg::SINE_BITS-1:0] data_reg;

    for (genvar k = 0; k < Entries; k++)
    begin : g_entry
        assign rom[k] = mtk_pkg::quarter_entry(k);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= rom[addr];
        end
    end

    assign data = data_reg;

endmodule : mtk_sine_rom
`default_nettype wire

// ===== rtl/core/mtk_sequencer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mtk_sequencer
// Symbol unit state, sample counter and phase accumulator; issues the
// sine table address and the flags for each accepted word.
// ----------------------------------------------------------------------------
module mtk_sequencer (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               en,
    input  wire logic                               take,
    input  wire logic                               op,
    input  wire logic [1:0]                         symbol,
    input  wire logic [mtk_pkg::SPU_BITS-1:0]       samples_per_unit,
    input  wire logic [mtk_pkg::STEP_BITS-1:0]      phase_step,
    output logic      [mtk_pkg::SINE_IDX_BITS-1:0]  rom_addr,
    output mtk_pkg::mtk_stage_t                     stage
);

    localparam int PB = mtk_pkg::PHASE_BITS;
    localparam int AB = mtk_pkg::SINE_ADDR_BITS;

    logic [mtk_pkg::PATTERN_BITS-1:0] pattern_reg, pattern_next;
    logic [mtk_pkg::UNITS_BITS-1:0]   units_reg, units_next;
    logic [mtk_pkg::SPU_BITS-1:0]     count_reg, count_next;
    logic [PB-1:0]                    phase_reg, phase_next;
    mtk_pkg::mtk_stage_t              stage_reg, stage_next;

    logic                             busy;
    logic [mtk_pkg::SPU_BITS-1:0]     limit;
    logic [mtk_pkg::SPU_BITS-1:0]     count_inc;
    logic [PB-1:0]                    phase_sum;
    logic [AB+1:0]                    idx;
    logic [AB-1:0]                    off;

    assign busy      = (units_reg != '0);
    assign limit     = (samples_per_unit == '0) ? mtk_pkg::SPU_BITS'(1) : samples_per_unit;
    assign count_inc = count_reg + mtk_pkg::SPU_BITS'(1);
    assign phase_sum = phase_reg + PB'(phase_step);

    always_comb
    begin
        pattern_next = pattern_reg;
        units_next   = units_reg;
        count_next   = count_reg;
        phase_next   = phase_reg;
        stage_next   = '0;
        stage_next.valid = take;
        if (take)
        begin
            if (op == mtk_pkg::OP_LOAD)
            begin
                if (!busy && symbol != mtk_pkg::SYM_INVALID)
                begin
                    unique case (symbol)
                        mtk_pkg::SYM_DOT:
                        begin
                            pattern_next = mtk_pkg::PAT_DOT;
                            units_next   = mtk_pkg::LEN_DOT;
                        end
                        mtk_pkg::SYM_DASH:
                        begin
                            pattern_next = mtk_pkg::PAT_DASH;
                            units_next   = mtk_pkg::LEN_DASH;
                        end
                        default:
                        begin
                            pattern_next = mtk_pkg::PAT_SPACE;
                            units_next   = mtk_pkg::LEN_SPACE;
                        end
                    endcase
                    count_next = '0;
                    phase_next = '0;
                    stage_next.accepted = 1'b1;
                end
            end
            else if (busy)
            begin
                stage_next.sample_valid = 1'b1;
                stage_next.tone_on      = pattern_reg[0];
                count_next = count_inc;
                phase_next = phase_sum;
                // end of unit, also when the counter wraps
                if (count_inc >= limit || count_inc == '0)
                begin
                    count_next   = '0;
                    phase_next   = '0;
                    pattern_next = pattern_reg >> 1;
                    units_next   = units_reg - mtk_pkg::UNITS_BITS'(1);
                end
            end
        end
        stage_next.busy_res = (units_next != '0);
        stage_next.negative = idx[AB+1];
    end

    // quadrant from the top phase bits, mirrored in odd quadrants
    assign idx = phase_reg[PB-1 -: AB+2];
    assign off = idx[AB-1:0];
    assign rom_addr = idx[AB] ? (mtk_pkg::SINE_IDX_BITS'(mtk_pkg::SINE_TABLE_DEPTH)
                                 - {1'b0, off})
                              : {1'b0, off};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg <= '0;
            units_reg   <= '0;
            count_reg   <= '0;
            phase_reg   <= '0;
            stage_reg   <= '0;
        end
        else if (en)
        begin
            pattern_reg <= pattern_next;
            units_reg   <= units_next;
            count_reg   <= count_next;
            phase_reg   <= phase_next;
            stage_reg   <= stage_next;
        end
    end

    assign stage = stage_reg;

endmodule : mtk_sequencer
`default_nettype wire

// ===== rtl/core/mtk_tone_out.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mtk_tone_out
// Scales the table magnitude by the amplitude, applies the sign and holds
// the result word.
// ----------------------------------------------------------------------------
module mtk_tone_out (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   en,
    input  wire mtk_pkg::mtk_stage_t                    stage,
    input  wire logic [mtk_pkg::SINE_BITS-1:0]          mag,
    input  wire logic [mtk_pkg::AMP_BITS-1:0]           amplitude,
    output logic                                        res_valid,
    output logic signed [mtk_pkg::SAMPLE_BITS-1:0]      sample,
    output logic                                        sample_valid,
    output logic                                        accepted,
    output logic                                        busy_res
);

    localparam int ProdBits = mtk_pkg::SINE_BITS + mtk_pkg::AMP_BITS;

    logic [ProdBits-1:0]                  prod;
    logic [mtk_pkg::SAMPLE_BITS-1:0]      scaled;
    logic [mtk_pkg::SAMPLE_BITS-1:0]      sample_next;
    logic [mtk_pkg::SAMPLE_BITS-1:0]      sample_reg;
    logic                                 valid_reg;
    logic                                 sample_valid_reg;
    logic                                 accepted_reg;
    logic                                 busy_reg;

    assign prod   = ProdBits'(mag) * ProdBits'(amplitude);
    // truncation toward zero on the magnitude
    assign scaled = mtk_pkg::SAMPLE_BITS'(prod >> 15);

    always_comb
    begin
        if (!stage.tone_on)
        begin
            sample_next = '0;
        end
        else if (stage.negative)
        begin
            sample_next = '0 - scaled;
        end
        else
        begin
            sample_next = scaled;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= stage.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sample_reg       <= sample_next;
            sample_valid_reg <= stage.sample_valid;
            accepted_reg     <= stage.accepted;
            busy_reg         <= stage.busy_res;
        end
    end

    assign res_valid    = valid_reg;
    assign sample       = sample_reg;
    assign sample_valid = sample_valid_reg;
    assign accepted     = accepted_reg;
    assign busy_res     = busy_reg;

endmodule : mtk_tone_out
`default_nettype wire

// ===== rtl/core/morse_tone_keyer_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// morse_tone_keyer_unit
// Morse keyer with a sine sidetone producing signed 16-bit pcm samples.
//
// Channels: cmd takes one word per tick (op = tick) or symbol load
// (op = load, symbol = dot, dash or space); res gives exactly one word
// per cmd word, in order: sample, sample_valid, accepted, busy_res.
// cfg writes samples_per_unit (index 0), phase_step (1) and amplitude (2);
// it is always ready and should only be used while the block is idle.
// Pipeline: sequencer flags and sine table read are registered together
// first, then scaling goes into the output register. Throughput: one word
// per cycle while res is taken; both stages move together, so when res
// stalls cmd.ready drops in the same cycle and every stage holds its word.
// Reset: registers return to 4410 samples per unit, phase step 102261126
// and amplitude 32000; no symbol is playing and the pipeline is empty.
// ----------------------------------------------------------------------------
module morse_tone_keyer_unit (
    input  wire logic   clk,
    input  wire logic   rst_n,
    mtk_cmd_if.sink     cmd,
    mtk_res_if.source   res,
    mtk_cfg_if.sink     cfg
);

    logic [mtk_pkg::SPU_BITS-1:0]       spu_reg;
    logic [mtk_pkg::STEP_BITS-1:0]      step_reg;
    logic [mtk_pkg::AMP_BITS-1:0]       amp_reg;

    logic                               en;
    logic                               take;
    logic [mtk_pkg::SINE_IDX_BITS-1:0]  rom_addr;
    logic [mtk_pkg::SINE_BITS-1:0]      rom_data;
    mtk_pkg::mtk_stage_t                stage;

    // whole pipeline advances unless a finished word is waiting
    assign en        = !res.valid || res.ready;
    assign cmd.ready = en;
    assign take      = cmd.valid && en;
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spu_reg  <= mtk_pkg::SPU_RESET;
            step_reg <= mtk_pkg::STEP_RESET;
            amp_reg  <= mtk_pkg::AMP_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                mtk_pkg::CFG_SAMPLES_PER_UNIT: spu_reg  <= cfg.data[mtk_pkg::SPU_BITS-1:0];
                mtk_pkg::CFG_PHASE_STEP:       step_reg <= cfg.data;
                mtk_pkg::CFG_AMPLITUDE:        amp_reg  <= cfg.data[mtk_pkg::AMP_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    mtk_sequencer u_sequencer (
        .clk              (clk),
        .rst_n            (rst_n),
        .en               (en),
        .take             (take),
        .op               (cmd.op),
        .symbol           (cmd.symbol),
        .samples_per_unit (spu_reg),
        .phase_step       (step_reg),
        .rom_addr         (rom_addr),
        .stage            (stage)
    );

    mtk_sine_rom u_sine_rom (
        .clk  (clk),
        .en   (en),
        .addr (rom_addr),
        .data (rom_data)
    );

    mtk_tone_out u_tone_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .stage        (stage),
        .mag          (rom_data),
        .amplitude    (amp_reg),
        .res_valid    (res.valid),
        .sample       (res.sample),
        .sample_valid (res.sample_valid),
        .accepted     (res.accepted),
        .busy_res     (res.busy_res)
    );

endmodule : morse_tone_keyer_unit
`default_nettype wire
